// ----- sv/rmslm_pkg.sv -----
// ----------------------------------------------------------------------------
// rmslm_pkg - shared constants for the RMS level meter
// Widths, register indexes, reset values and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rmslm_pkg;

  // Averaging window, a power of two
  localparam int WINDOW_LOG2 = 3;
  localparam int WINDOW      = 1 << WINDOW_LOG2;
  localparam int PTR_W       = WINDOW_LOG2;

  localparam int SAMPLE_W = 10;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int SUM_W    = SQ_W + WINDOW_LOG2;
  localparam int MS_W     = SQ_W;
  localparam int RMS_W    = SAMPLE_W;
  localparam int LEVEL_W  = 8;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = SAMPLE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_LEVEL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_OFFSET   = CFG_IDX_W'(1);
  localparam logic [SAMPLE_W-1:0]  REFERENCE_RESET     = SAMPLE_W'(170);
  localparam logic [SAMPLE_W-1:0]  OFFSET_RESET        = SAMPLE_W'(512);

  // Fixed-point log: Q30 mantissa, Q24 log2, Q8.8 decibels
  localparam int MANT_W      = 31;
  localparam int MANT_FRAC   = 30;
  localparam int LOG_FRAC_W  = 24;
  localparam int EXP_W       = 4;
  localparam int LG_W        = LOG_FRAC_W + EXP_W;
  localparam int STEP_W      = 5;
  localparam int K_W         = 27;
  localparam int PROD_W      = LG_W + K_W;
  localparam int ROUND_SHIFT = 40;
  localparam int DB_W        = 14;
  localparam logic [K_W-1:0] DB_PER_OCTAVE = K_W'(101008905);

  localparam logic signed [LEVEL_W-1:0] LEVEL_SILENT = -LEVEL_W'(signed'(128));

endpackage

`default_nettype wire

// ----- sv/rmslm_fifo.sv -----
// ----------------------------------------------------------------------------
// rmslm_fifo - two-word queue between front and back
// Carries mean-square words so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module rmslm_fifo (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire logic [rmslm_pkg::MS_W-1:0] push_data,
  input  wire logic                      pop,
  output logic [rmslm_pkg::MS_W-1:0]     head,
  output logic                           empty,
  output logic                           full
);
  import rmslm_pkg::*;

  logic [MS_W-1:0] mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");

endmodule

`default_nettype wire

// ----- sv/rmslm_log.sv -----
// ----------------------------------------------------------------------------
// rmslm_log - iterative 20*log10(x) in Q8.8
// One squaring of the Q30 mantissa per cycle, then one scaling multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module rmslm_log (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rmslm_pkg::RMS_W-1:0]   x,
  output logic                               busy,
  output logic                               done,
  output logic [rmslm_pkg::DB_W-1:0]         db
);
  import rmslm_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_ITER, L_MUL, L_FIN} log_state_t;

  log_state_t        state;
  logic [MANT_W-1:0] m;
  logic [LG_W-1:0]   lg;
  logic [STEP_W-1:0] step;
  logic [PROD_W-1:0] prod;

  logic [EXP_W-1:0]    n;
  logic [STEP_W-1:0]   shamt;
  logic [MANT_W-1:0]   m_init;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     msq;
  logic [PROD_W-1:0]   rounded;

  // Position of the top set bit
  always_comb begin
    n = '0;
    for (int i = 0; i < RMS_W; i++) begin
      if (x[i]) n = EXP_W'(i);
    end
  end

  assign shamt  = STEP_W'(MANT_FRAC) - STEP_W'(n);
  assign m_init = MANT_W'(x) << shamt;
  assign sq     = (2*MANT_W)'(m) * (2*MANT_W)'(m);
  assign msq    = sq[MANT_FRAC +: MANT_W+1];

  assign rounded = prod + (PROD_W'(1) << (ROUND_SHIFT - 1));
  assign db      = rounded[ROUND_SHIFT +: DB_W];
  assign busy    = (state != L_IDLE);
  assign done    = (state == L_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      case (state)
        L_IDLE: begin
          if (start) begin
            m     <= m_init;
            lg    <= {n, LOG_FRAC_W'(0)};
            step  <= STEP_W'(LOG_FRAC_W - 1);
            state <= L_ITER;
          end
        end
        L_ITER: begin
          // Square; a result of two or more carries one bit of the log
          if (msq[MANT_W]) begin
            m        <= msq[MANT_W:1];
            lg[step] <= 1'b1;
          end else begin
            m <= msq[MANT_W-1:0];
          end
          if (step == '0) state <= L_MUL;
          else            step  <= step - STEP_W'(1);
        end
        L_MUL: begin
          prod  <= PROD_W'(lg) * PROD_W'(DB_PER_OCTAVE);
          state <= L_FIN;
        end
        L_FIN: begin
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("log unit started while busy");

endmodule

`default_nettype wire

// ----- sv/rmslm_front.sv -----
// ----------------------------------------------------------------------------
// rmslm_front - sample intake and running sum of squares
// Removes the offset, keeps a ring of squares and queues the mean square.
// ----------------------------------------------------------------------------
`default_nettype none

module rmslm_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rmslm_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [rmslm_pkg::SAMPLE_W-1:0] sample_offset,
  input  wire logic                           fifo_full,
  output logic                                push,
  output logic [rmslm_pkg::MS_W-1:0]          push_data
);
  import rmslm_pkg::*;

  logic [SQ_W-1:0]  ring [WINDOW];
  logic [PTR_W-1:0] wp;
  logic [SUM_W-1:0] sum;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        neg;
  logic [SAMPLE_W-1:0]      mag;
  logic [SQ_W-1:0]          sq;
  logic [SUM_W-1:0]         sum_next;

  assign diff = signed'({1'b0, sample}) - signed'({1'b0, sample_offset});
  assign neg  = -diff;
  assign mag  = diff[DIFF_W-1] ? neg[SAMPLE_W-1:0] : diff[SAMPLE_W-1:0];
  assign sq   = SQ_W'(mag) * SQ_W'(mag);

  // Swap the oldest square for the new one
  assign sum_next  = sum + SUM_W'(sq) - SUM_W'(ring[wp]);
  assign push_data = sum_next[SUM_W-1:WINDOW_LOG2];

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) ring[i] <= '0;
      wp  <= '0;
      sum <= '0;
    end else if (push) begin
      ring[wp] <= sq;
      wp       <= wp + PTR_W'(1);
      sum      <= sum_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rmslm_back.sv -----
// ----------------------------------------------------------------------------
// rmslm_back - square root, decibel level and result register
// Takes mean-square words from the queue and produces one result word each.
// ----------------------------------------------------------------------------
`default_nettype none

module rmslm_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           fifo_empty,
  input  wire logic [rmslm_pkg::MS_W-1:0]     fifo_head,
  output logic                                pop,
  input  wire logic [rmslm_pkg::SAMPLE_W-1:0] reference_level,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [rmslm_pkg::RMS_W-1:0]         rms,
  output logic signed [rmslm_pkg::LEVEL_W-1:0] level_db,
  output logic                                level_valid
);
  import rmslm_pkg::*;

  localparam int REM_W = RMS_W + 2;
  localparam int CNT_W = $clog2(RMS_W);

  typedef enum logic [2:0] {S_IDLE, S_SQRT, S_LOG_RMS, S_LOG_REF, S_EMIT} back_state_t;

  back_state_t               state;
  logic [MS_W-1:0]           radicand;
  logic [REM_W-1:0]          rem;
  logic [RMS_W-1:0]          root;
  logic [CNT_W-1:0]          cnt;
  logic [DB_W-1:0]           db_rms;
  logic                      log_start;
  logic [RMS_W-1:0]          res_rms;
  logic signed [LEVEL_W-1:0] res_level;
  logic                      res_valid;

  logic [REM_W-1:0]       rem_sh;
  logic [REM_W-1:0]       trial;
  logic [REM_W-1:0]       rem_next;
  logic [RMS_W-1:0]       root_next;
  logic [SAMPLE_W-1:0]    ref_eff;
  logic [RMS_W-1:0]       log_x;
  logic                   log_busy;
  logic                   log_done;
  logic [DB_W-1:0]        log_db;
  logic signed [DB_W:0]   db_diff;
  logic [DB_W:0]          db_neg;
  logic [DB_W-1:0]        db_mag;
  logic [LEVEL_W-1:0]     q;
  logic signed [LEVEL_W-1:0] level;
  logic                   out_free;
  logic                   sqrt_last;

  // Restoring square root, two radicand bits per step
  assign rem_sh = {rem[REM_W-3:0], radicand[MS_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  always_comb begin
    if (rem_sh >= trial) begin
      rem_next  = rem_sh - trial;
      root_next = {root[RMS_W-2:0], 1'b1};
    end else begin
      rem_next  = rem_sh;
      root_next = {root[RMS_W-2:0], 1'b0};
    end
  end

  assign ref_eff = (reference_level == '0) ? SAMPLE_W'(1) : reference_level;
  assign log_x   = (state == S_LOG_REF) ? ref_eff : root;

  rmslm_log u_log (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .x     (log_x),
    .busy  (log_busy),
    .done  (log_done),
    .db    (log_db)
  );

  // Truncate the Q8.8 difference toward zero
  assign db_diff = signed'({1'b0, db_rms}) - signed'({1'b0, log_db});
  assign db_neg  = -db_diff;
  assign db_mag  = db_diff[DB_W] ? db_neg[DB_W-1:0] : db_diff[DB_W-1:0];
  assign q       = LEVEL_W'(db_mag >> 8);
  assign level   = db_diff[DB_W] ? -signed'(q) : signed'(q);

  assign pop       = (state == S_IDLE) && !fifo_empty;
  assign out_free  = !out_valid || !out_stall;
  assign sqrt_last = (state == S_SQRT) && (cnt == CNT_W'(RMS_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      log_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Kick the log unit for the rms, then again for the reference
      log_start <= (sqrt_last && root_next != '0) || (state == S_LOG_RMS && log_done);
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!fifo_empty) begin
            radicand <= fifo_head;
            rem      <= '0;
            root     <= '0;
            cnt      <= '0;
            state    <= S_SQRT;
          end
        end
        S_SQRT: begin
          radicand <= radicand << 2;
          rem      <= rem_next;
          root     <= root_next;
          cnt      <= cnt + CNT_W'(1);
          if (sqrt_last) begin
            if (root_next == '0) begin
              res_rms   <= '0;
              res_level <= LEVEL_SILENT;
              res_valid <= 1'b0;
              state     <= S_EMIT;
            end else begin
              state     <= S_LOG_RMS;
            end
          end
        end
        S_LOG_RMS: begin
          if (log_done) begin
            db_rms    <= log_db;
            state     <= S_LOG_REF;
          end
        end
        S_LOG_REF: begin
          if (log_done) begin
            res_rms   <= root;
            res_level <= level;
            res_valid <= 1'b1;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rms         <= res_rms;
            level_db    <= res_level;
            level_valid <= res_valid;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_silent_word: assert property (@(posedge clk) disable iff (rst)
      out_valid && !level_valid |-> rms == '0 && level_db == LEVEL_SILENT)
    else $error("level marked invalid on a nonzero rms");
  a_log_owned: assert property (@(posedge clk) disable iff (rst)
      log_busy |-> state == S_LOG_RMS || state == S_LOG_REF)
    else $error("log unit running outside its states");

endmodule

`default_nettype wire

// ----- sv/rms_level_meter.sv -----
// Path from an accepted sample to its result word: the queue, 10 square-root
// steps, two log passes on the shared log unit, then one emit step.
// The back part takes one word at a time from the queue and starts the next only in
// idle; a window of silence gives rms zero and skips both log passes.
// Reset: synchronous; clears the ring, write pointer, running sum, queue and
// output, and loads reference level 170 and sample offset 512.
// ----------------------------------------------------------------------------
// rms_level_meter - windowed RMS and decibel level meter
// Configuration registers, front intake, queue and back computation.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_level_meter (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [rmslm_pkg::SAMPLE_W-1:0]   sample,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [rmslm_pkg::RMS_W-1:0]           rms,
  output logic signed [rmslm_pkg::LEVEL_W-1:0]  level_db,
  output logic                                  level_valid,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rmslm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rmslm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rmslm_pkg::*;

  logic [SAMPLE_W-1:0] reference_level;
  logic [SAMPLE_W-1:0] sample_offset;

  logic            push;
  logic [MS_W-1:0] push_data;
  logic            pop;
  logic [MS_W-1:0] fifo_head;
  logic            fifo_empty;
  logic            fifo_full;

  assign cfg_ready = 1'b1;

  // Unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_level <= REFERENCE_RESET;
      sample_offset   <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REFERENCE_LEVEL: reference_level <= cfg_data;
        CFG_SAMPLE_OFFSET:   sample_offset   <= cfg_data;
        default: ;
      endcase
    end
  end

  rmslm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample        (sample),
    .sample_offset (sample_offset),
    .fifo_full     (fifo_full),
    .push          (push),
    .push_data     (push_data)
  );

  rmslm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (fifo_head),
    .empty     (fifo_empty),
    .full      (fifo_full)
  );

  rmslm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .fifo_empty      (fifo_empty),
    .fifo_head       (fifo_head),
    .pop             (pop),
    .reference_level (reference_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .rms             (rms),
    .level_db        (level_db),
    .level_valid     (level_valid)
  );

endmodule

`default_nettype wire
